// ===== rtl/snn_pkg.sv =====
// Package for the spiking neuron network step block.
// Holds sizes, register indexes, fixed-point constants, the synapse write type
// and the 32-bit saturation function. No dependencies.
package snn_pkg;

  localparam int NEURONS   = 10;
  localparam int NIDX_W    = $clog2(NEURONS);
  localparam int CNT_W     = $clog2(NEURONS + 1);
  localparam int WADDR_W   = $clog2(NEURONS * NEURONS);
  localparam int SPIKE_W   = 10;
  localparam int DATA_W    = 32;
  localparam int WGT_W     = 16;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = DATA_W + 8;

  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_RATE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_SENSITIVITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_POTENTIAL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_INCREMENT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THRESHOLD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_POTENTIAL    = 3'd5;

  localparam logic signed [DATA_W-1:0] RST_RECOVERY_RATE        = 32'sd26214;
  localparam logic signed [DATA_W-1:0] RST_RECOVERY_SENSITIVITY = -32'sd6554;
  localparam logic signed [DATA_W-1:0] RST_RESET_POTENTIAL      = -32'sd3604480;
  localparam logic signed [DATA_W-1:0] RST_RESET_INCREMENT      = 32'sd262144;
  localparam logic signed [DATA_W-1:0] RST_SPIKE_THRESHOLD      = 32'sd1966080;
  localparam logic signed [DATA_W-1:0] RST_INITIAL_POTENTIAL    = -32'sd3932160;
  localparam logic signed [DATA_W-1:0] RST_INITIAL_RECOVERY     = 32'sd393240;

  localparam logic signed [12:0]       K_SQ    = 13'sd2621;
  localparam logic signed [19:0]       K_LIN   = 20'sd268698;
  localparam logic signed [DATA_W-1:0] K_CONST = 32'sd7077888;

  typedef struct packed {
    logic                      en;
    logic [WADDR_W-1:0]        addr;
    logic signed [WGT_W-1:0]   data;
  } syn_wr_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/spiking_neuron_network_step.sv =====
// Top level of the spiking neuron network step block.
// Holds the tick sequencer, membrane and recovery memories and configuration.
// Depends on snn_pkg and snn_synapse.
//
// A weight write transaction completes in the cycle it is accepted and gives
// no result. A tick transaction keeps busy high while it walks the neurons,
// and the spike vector appears on out_spike_vector with out_valid high for
// one cycle right after. The per-neuron walk reads one weight a cycle from
// the synapse memory, loads the neuron, then takes ten steps of the shared
// 32x32 multiplier and adders for two half-steps, the recovery update and
// the spike check. The receiver cannot stall, so the result must be taken in
// the cycle it is shown. The user must write configuration only while busy
// is low; the block itself does not enforce it. Writing the initial
// potential reloads every neuron at once.
module spiking_neuron_network_step (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_mode,
  input  logic [snn_pkg::IDX_W-1:0]        in_post_index,
  input  logic [snn_pkg::IDX_W-1:0]        in_pre_index,
  input  logic signed [snn_pkg::WGT_W-1:0] in_weight,
  input  logic signed [snn_pkg::DATA_W-1:0] in_external_current,
  output logic                             out_valid,
  output logic [snn_pkg::SPIKE_W-1:0]      out_spike_vector,
  input  logic                             cfg_we,
  input  logic [snn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [snn_pkg::DATA_W-1:0]       cfg_data
);
  import snn_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_CUR  = 4'd2;
  localparam logic [3:0] S_H1   = 4'd3;
  localparam logic [3:0] S_H2   = 4'd4;
  localparam logic [3:0] S_H3   = 4'd5;
  localparam logic [3:0] S_B1   = 4'd6;
  localparam logic [3:0] S_B2   = 4'd7;
  localparam logic [3:0] S_B3   = 4'd8;
  localparam logic [3:0] S_B4   = 4'd9;

  logic [3:0] state_r, state_nxt;

  logic signed [DATA_W-1:0] a_r, b_r, c_r, d_r, thr_r, ip_r, u0_r;
  logic signed [63:0]       cfg_prod;

  logic signed [DATA_W-1:0] vmem [NEURONS];
  logic signed [DATA_W-1:0] umem [NEURONS];
  logic signed [DATA_W-1:0] vrd_r, urd_r;
  logic [NEURONS-1:0]       mvalid_r;

  logic [NIDX_W-1:0]        k_r;
  logic [CNT_W-1:0]         jc_r;
  logic [WADDR_W-1:0]       wbase_r;
  logic                     half_r;
  logic                     fire_d_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  addend;
  logic [NEURONS-1:0]       fired_r, fired_all, last_fired_r;

  logic signed [DATA_W-1:0] cur_r, v_r, u_r, diff_r;
  logic signed [63:0]       prod_r, mul_p;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [35:0]       lin_r;
  logic signed [44:0]       sqt_r;
  logic signed [45:0]       dv;
  logic signed [DATA_W-1:0] v_half, u_new, u_fin, v_fin;
  logic                     spike;

  logic                     accept;
  logic                     last_neuron;
  logic                     acc_last;
  syn_wr_t                  syn_wr;
  logic [WADDR_W-1:0]       syn_rd_addr;
  logic signed [WGT_W-1:0]  syn_rd_data;

  logic                     out_valid_r;
  logic [SPIKE_W-1:0]       out_spike_r;

  assign accept      = start && (state_r == S_IDLE);
  assign busy        = (state_r != S_IDLE);
  assign last_neuron = (k_r == NIDX_W'(NEURONS - 1));
  assign acc_last    = (jc_r == CNT_W'(NEURONS));

  always_comb begin
    syn_wr.en   = accept && !in_mode && (32'(in_post_index) < NEURONS) &&
                  (32'(in_pre_index) < NEURONS);
    syn_wr.addr = WADDR_W'(in_post_index) * WADDR_W'(NEURONS) + WADDR_W'(in_pre_index);
    syn_wr.data = (in_post_index == in_pre_index) ? '0 : in_weight;
  end

  assign syn_rd_addr = acc_last ? wbase_r : (wbase_r + WADDR_W'(jc_r));

  snn_synapse u_synapse (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (syn_wr),
    .rd_addr (syn_rd_addr),
    .rd_data (syn_rd_data)
  );

  assign cfg_prod = signed'(cfg_data) * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r   <= RST_RECOVERY_RATE;
      b_r   <= RST_RECOVERY_SENSITIVITY;
      c_r   <= RST_RESET_POTENTIAL;
      d_r   <= RST_RESET_INCREMENT;
      thr_r <= RST_SPIKE_THRESHOLD;
      ip_r  <= RST_INITIAL_POTENTIAL;
      u0_r  <= RST_INITIAL_RECOVERY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RECOVERY_RATE:        a_r   <= signed'(cfg_data);
        REG_RECOVERY_SENSITIVITY: b_r   <= signed'(cfg_data);
        REG_RESET_POTENTIAL:      c_r   <= signed'(cfg_data);
        REG_RESET_INCREMENT:      d_r   <= signed'(cfg_data);
        REG_SPIKE_THRESHOLD:      thr_r <= signed'(cfg_data);
        REG_INITIAL_POTENTIAL: begin
          ip_r <= signed'(cfg_data);
          u0_r <= sat32(cfg_prod >>> 16);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state_r)
      S_B1: begin
        mul_a = b_r;
        mul_b = v_r;
      end
      S_B3: begin
        mul_a = a_r;
        mul_b = diff_r;
      end
      default: begin
        mul_a = v_r;
        mul_b = v_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign addend = (jc_r != '0 && fire_d_r) ? (ACC_W'(syn_rd_data) <<< 8) : '0;

  always_comb begin
    dv     = 46'(sqt_r) + 46'(lin_r) + 46'(K_CONST) - 46'(u_r) + 46'(cur_r);
    v_half = sat32(64'(v_r) + 64'(dv >>> 2));
    u_new  = sat32(64'(u_r) + (prod_r >>> 17));
    spike  = (v_r >= thr_r);
    u_fin  = spike ? sat32(64'(u_new) + 64'(d_r)) : u_new;
    v_fin  = spike ? c_r : v_r;
    fired_all = fired_r;
    fired_all[k_r] = spike;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && in_mode) state_nxt = S_ACC;
      S_ACC:  if (acc_last) state_nxt = S_CUR;
      S_CUR:  state_nxt = S_H1;
      S_H1:   state_nxt = S_H2;
      S_H2:   state_nxt = S_H3;
      S_H3:   state_nxt = half_r ? S_B1 : S_H1;
      S_B1:   state_nxt = S_B2;
      S_B2:   state_nxt = S_B3;
      S_B3:   state_nxt = S_B4;
      S_B4:   state_nxt = last_neuron ? S_IDLE : S_ACC;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mvalid_r     <= '0;
      last_fired_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we && cfg_index == REG_INITIAL_POTENTIAL) begin
        mvalid_r <= '0;
      end else if (state_r == S_B4) begin
        mvalid_r[k_r] <= 1'b1;
      end
      if (state_r == S_B4 && last_neuron) begin
        last_fired_r <= fired_all;
        out_valid_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_B4) begin
      vmem[k_r] <= v_fin;
      umem[k_r] <= u_fin;
    end
    vrd_r <= vmem[k_r];
    urd_r <= umem[k_r];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept && in_mode) begin
          acc_r   <= ACC_W'(in_external_current);
          k_r     <= '0;
          jc_r    <= '0;
          wbase_r <= '0;
          fired_r <= '0;
        end
      end
      S_ACC: begin
        if (!acc_last) begin
          fire_d_r <= last_fired_r[jc_r[NIDX_W-1:0]];
        end
        acc_r <= acc_r + addend;
        jc_r  <= jc_r + CNT_W'(1);
      end
      S_CUR: begin
        cur_r  <= sat32(64'(acc_r));
        v_r    <= mvalid_r[k_r] ? vrd_r : ip_r;
        u_r    <= mvalid_r[k_r] ? urd_r : u0_r;
        half_r <= 1'b0;
      end
      S_H1: begin
        prod_r <= mul_p;
        lin_r  <= 36'((64'(v_r) * 64'(K_LIN)) >>> 16);
      end
      S_H2: begin
        sqt_r <= 45'(((prod_r >>> 16) * 64'(K_SQ)) >>> 16);
      end
      S_H3: begin
        v_r    <= v_half;
        half_r <= 1'b1;
      end
      S_B1: begin
        prod_r <= mul_p;
      end
      S_B2: begin
        diff_r <= sat32((prod_r >>> 16) - 64'(u_r));
      end
      S_B3: begin
        prod_r <= mul_p;
      end
      S_B4: begin
        fired_r     <= fired_all;
        out_spike_r <= SPIKE_W'(fired_all);
        k_r         <= k_r + NIDX_W'(1);
        wbase_r     <= wbase_r + WADDR_W'(NEURONS);
        jc_r        <= '0;
        acc_r       <= '0;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_spike_vector = out_spike_r;

endmodule

// ===== rtl/snn_synapse.sv =====
// Synapse weight store: one write port and one registered read port.
// Entries never written read as zero through per-entry valid bits.
// Depends on snn_pkg.
module snn_synapse (
  input  logic                           clk,
  input  logic                           rst_n,
  input  snn_pkg::syn_wr_t               wr,
  input  logic [snn_pkg::WADDR_W-1:0]    rd_addr,
  output logic signed [snn_pkg::WGT_W-1:0] rd_data
);
  import snn_pkg::*;

  logic signed [WGT_W-1:0] mem [NEURONS*NEURONS];
  logic [NEURONS*NEURONS-1:0] valid_r;
  logic signed [WGT_W-1:0] rd_raw_r;
  logic rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_raw_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_raw_r : '0;

endmodule
